// ===== rtl/local_apic_timer_core_defines.svh =====
// Assertion macros of the local APIC timer checker file, lat_checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LOCAL_APIC_TIMER_CORE_DEFINES_SVH
`define LOCAL_APIC_TIMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LAT_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("local APIC timer check failed in %m");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LAT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("local APIC timer check failed in %m");

`endif

// ===== rtl/lat_pkg.sv =====
// Types, register offsets and helper functions of the local APIC timer.
// No dependencies; used by the interfaces, the design modules and the bench.
package lat_pkg;

  localparam int unsigned CountWidth = 32;  // timer counter width, 8 to 32
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned OfsWidth   = 10;
  localparam int unsigned PreWidth   = 7;
  localparam int unsigned VecWidth   = 8;

  // Register byte offsets in the APIC page
  localparam logic [OfsWidth-1:0] OfsTpr  = 10'h080;
  localparam logic [OfsWidth-1:0] OfsLvt  = 10'h320;
  localparam logic [OfsWidth-1:0] OfsInit = 10'h380;
  localparam logic [OfsWidth-1:0] OfsCur  = 10'h390;
  localparam logic [OfsWidth-1:0] OfsDiv  = 10'h3E0;

  // LVT timer bit positions
  localparam int unsigned LvtMaskBit     = 16;
  localparam int unsigned LvtPeriodicBit = 17;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpWrite = 2'd1,
    OpRead  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 opcode;
    logic [OfsWidth-1:0] reg_offset;
    logic [DataWidth-1:0] write_data;
  } lat_in_t;

  typedef struct packed {
    logic [DataWidth-1:0] read_data;
    logic                 interrupt_pulse;
    logic [VecWidth-1:0]  interrupt_vector;
  } lat_out_t;

  // Prescaler bits that must all be set for a divide boundary.
  // Select is {b3,b1,b0} of the divide configuration.
  function automatic logic [PreWidth-1:0] div_mask(input logic [3:0] code);
    logic [2:0] sel;
    logic [PreWidth-1:0] m;
    sel = {code[3], code[1:0]};
    case (sel)
      3'd0:    m = 7'h01;   // /2
      3'd1:    m = 7'h03;   // /4
      3'd2:    m = 7'h07;   // /8
      3'd3:    m = 7'h0F;   // /16
      3'd4:    m = 7'h1F;   // /32
      3'd5:    m = 7'h3F;   // /64
      3'd6:    m = 7'h7F;   // /128
      default: m = 7'h00;   // /1, every tick
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/lat_if.sv =====
// Valid/ready channel interfaces of the local APIC timer.
// Depends on lat_pkg for the payload structs.
interface lat_in_if;
  import lat_pkg::*;
  logic    valid;
  logic    ready;
  lat_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lat_out_if;
  import lat_pkg::*;
  logic     valid;
  logic     ready;
  lat_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/local_apic_timer_core.sv =====
// Channel    | Dir | Payload                                 | Transaction
// in_i       | in  | opcode, reg_offset, write_data          | tick, write or read
// out_o      | out | read_data, interrupt_pulse, int. vector | one per input
//
// One transaction per cycle sustained while out_o is ready; each result is computed
// from the input register, held in the result register and offered on out_o from there.
// The rate is set by the update loop of the timer state registers.
// Reset (rst_ni low, async) empties both registers and sets the LVT masked.
// A stalled out_o holds its result; in_i keeps accepting until both registers
// are full.
// Top level of the local APIC timer; depends on lat_pkg, lat_if and the lat_ modules.
module local_apic_timer_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  lat_in_if.sink    in_i,
  lat_out_if.source out_o
);
  import lat_pkg::*;

  logic     item_valid;
  lat_in_t  item;
  lat_out_t result;
  logic     out_free;
  logic     advance;

  // Held item executes when the result register has room
  assign advance = item_valid && out_free;

  lat_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  lat_timer_regs u_timer_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  lat_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .out_o    (out_o),
    .load_i   (advance),
    .result_i (result),
    .free_o   (out_free)
  );
endmodule

// ===== rtl/lat_in_stage.sv =====
// Input register of the local APIC timer: holds one accepted transaction.
// Depends on lat_pkg and lat_in_if.
module lat_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  lat_in_if.sink           in_i,
  input  logic             advance_i,
  output logic             item_valid_o,
  output lat_pkg::lat_in_t item_o
);
  import lat_pkg::*;

  logic    valid_q, valid_d;
  lat_in_t item_q;
  logic    take;

  // Free when empty or when the held item moves on this cycle
  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_i.data;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ===== rtl/lat_timer_regs.sv =====
// Register file, prescaler and down counter of the local APIC timer.
// Executes one tick, write or read per advance; depends on lat_pkg.
module lat_timer_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  lat_pkg::lat_in_t  item_i,
  output lat_pkg::lat_out_t result_o
);
  import lat_pkg::*;

  logic [CountWidth-1:0] init_q, init_d;
  logic [CountWidth-1:0] cur_q, cur_d;
  logic [3:0]            div_q, div_d;
  logic [PreWidth-1:0]   pre_q, pre_d;
  logic [VecWidth-1:0]   vec_q, vec_d;
  logic                  masked_q, masked_d;
  logic                  periodic_q, periodic_d;
  logic [7:0]            tpr_q, tpr_d;

  logic [PreWidth-1:0]   mask;
  logic                  boundary;
  logic                  running;
  logic                  expire;

  // Divide boundary and expiry, from state before this tick
  assign mask     = div_mask(div_q);
  assign boundary = (pre_q & mask) == mask;
  assign running  = cur_q != '0;
  assign expire   = boundary && (cur_q == CountWidth'(1));

  // Next state and result
  always_comb begin
    init_d     = init_q;
    cur_d      = cur_q;
    div_d      = div_q;
    pre_d      = pre_q;
    vec_d      = vec_q;
    masked_d   = masked_q;
    periodic_d = periodic_q;
    tpr_d      = tpr_q;
    result_o   = '0;
    case (item_i.opcode)
      OpTick: begin
        pre_d = pre_q + PreWidth'(1);
        if (boundary && running) begin
          if (expire) begin
            cur_d = periodic_q ? init_q : '0;
            result_o.interrupt_pulse  = !masked_q;
            result_o.interrupt_vector = masked_q ? '0 : vec_q;
          end else begin
            cur_d = cur_q - CountWidth'(1);
          end
        end
      end
      OpWrite: begin
        case (item_i.reg_offset)
          OfsTpr: tpr_d = item_i.write_data[7:0];
          OfsLvt: begin
            vec_d      = item_i.write_data[VecWidth-1:0];
            masked_d   = item_i.write_data[LvtMaskBit];
            periodic_d = item_i.write_data[LvtPeriodicBit];
          end
          OfsInit: begin
            init_d = item_i.write_data[CountWidth-1:0];
            cur_d  = item_i.write_data[CountWidth-1:0];
            pre_d  = '0;
          end
          OfsDiv: div_d = {item_i.write_data[3], 1'b0, item_i.write_data[1:0]};
          default: ;  // current count and unknown offsets ignore writes
        endcase
      end
      OpRead: begin
        case (item_i.reg_offset)
          OfsTpr:  result_o.read_data = DataWidth'(tpr_q);
          OfsLvt:  result_o.read_data = {14'd0, periodic_q, masked_q, 8'd0, vec_q};
          OfsInit: result_o.read_data = DataWidth'(init_q);
          OfsCur:  result_o.read_data = DataWidth'(cur_q);
          OfsDiv:  result_o.read_data = DataWidth'(div_q);
          default: result_o.read_data = '0;
        endcase
      end
      default: ;  // unknown opcode: no effect, zero result
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= '0;
      cur_q      <= '0;
      div_q      <= '0;
      pre_q      <= '0;
      vec_q      <= '0;
      masked_q   <= 1'b1;
      periodic_q <= 1'b0;
      tpr_q      <= '0;
    end else if (advance_i) begin
      init_q     <= init_d;
      cur_q      <= cur_d;
      div_q      <= div_d;
      pre_q      <= pre_d;
      vec_q      <= vec_d;
      masked_q   <= masked_d;
      periodic_q <= periodic_d;
      tpr_q      <= tpr_d;
    end
  end
endmodule

// ===== rtl/lat_out_stage.sv =====
// Result register of the local APIC timer, holds a result until taken.
// Depends on lat_pkg and lat_out_if.
module lat_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  lat_out_if.source         out_o,
  input  logic              load_i,
  input  lat_pkg::lat_out_t result_i,
  output logic              free_o
);
  import lat_pkg::*;

  logic     valid_q, valid_d;
  lat_out_t data_q;

  // Room when empty or when the held result is taken this cycle
  assign free_o  = !valid_q || out_o.ready;
  assign valid_d = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.data  = data_q;
endmodule

// ===== rtl/lat_checker.sv =====
// Port-level checks of the local APIC timer, bound to the top level.
// Depends on local_apic_timer_core_defines.svh.
`include "local_apic_timer_core_defines.svh"

module lat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] read_data_i,
  input logic        pulse_i,
  input logic [7:0]  vector_i
);
  // Vector only travels with a pulse
  `LAT_ASSERT_NOW(a_vec_needs_pulse, out_valid_i && !pulse_i, vector_i == 8'd0)
  // A pulse comes from a tick, which never carries read data
  `LAT_ASSERT_NOW(a_pulse_no_data, out_valid_i && pulse_i, read_data_i == 32'd0)
  // Input backpressure only when the pipe is full and output stalled
  `LAT_ASSERT_NOW(a_ready_stall, !in_ready_i, out_valid_i && !out_ready_i)
  // Stalled result holds
  `LAT_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(read_data_i) && $stable(pulse_i) && $stable(vector_i))
endmodule

bind local_apic_timer_core lat_checker u_lat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .read_data_i (out_o.data.read_data),
  .pulse_i     (out_o.data.interrupt_pulse),
  .vector_i    (out_o.data.interrupt_vector)
);

// ===== bench/tb_local_apic_timer_core.sv =====
// Self-checking bench for local_apic_timer_core: ticks, register writes and reads.
// Depends on lat_pkg, lat_if and the RTL; keeps its own copy of the timer state.
`timescale 1ns / 100ps

module tb_local_apic_timer_core;
  import lat_pkg::*;

  // Opcode value outside op_e, must do nothing
  localparam logic [1:0] OpReserved = 2'b11;
  // Divide select {b3,b1,b0}
  localparam logic [2:0] DivBy1 = 3'b111;
  localparam logic [2:0] DivBy2 = 3'b000;
  localparam logic [2:0] DivBy4 = 3'b001;
  localparam logic [OfsWidth-1:0] OfsUnused = 10'h3FF;

  localparam int unsigned WatchLimit = 1000;  // cycles without any transaction
  localparam int unsigned HoldCycles = 60;    // long receiver hold-off
  localparam int unsigned DrainCycles = 6;

  logic clk;
  logic rst_n;

  lat_in_if  in_if ();
  lat_out_if out_if ();

  local_apic_timer_core i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Timer state as the bench predicts it
  logic [CountWidth-1:0] tmr_initial;
  logic [CountWidth-1:0] tmr_current;
  logic [3:0]            tmr_divide;
  logic [PreWidth-1:0]   tmr_prescale;
  logic [VecWidth-1:0]   tmr_vector;
  logic                  tmr_masked;
  logic                  tmr_periodic;
  logic [7:0]            tmr_tpr;

  lat_out_t    pending_results[$];
  int unsigned fail_count;
  int unsigned burst_left;
  bit          sender_gaps;
  bit          rx_stalls;
  bit          hold_req;

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void timer_clear();
    tmr_initial  = '0;
    tmr_current  = '0;
    tmr_divide   = '0;
    tmr_prescale = '0;
    tmr_vector   = '0;
    tmr_masked   = 1'b1;
    tmr_periodic = 1'b0;
    tmr_tpr      = '0;
  endfunction

  // Advance the predicted timer by one transaction and return its result
  function automatic lat_out_t timer_next_result(input lat_in_t it);
    lat_out_t            r;
    logic [2:0]          sel;
    logic [PreWidth-1:0] bmask;
    logic                boundary;
    r = '0;
    case (it.opcode)
      OpTick: begin
        sel      = {tmr_divide[3], tmr_divide[1:0]};
        bmask    = (sel == DivBy1) ? '0 : PreWidth'((8'd2 << sel) - 8'd1);
        boundary = ((tmr_prescale & bmask) == bmask);
        tmr_prescale = tmr_prescale + 1'b1;
        if (boundary && tmr_current != '0) begin
          tmr_current = tmr_current - 1'b1;
          if (tmr_current == '0) begin
            if (!tmr_masked) begin
              r.interrupt_pulse  = 1'b1;
              r.interrupt_vector = tmr_vector;
            end
            if (tmr_periodic) tmr_current = tmr_initial;
          end
        end
      end
      OpWrite: begin
        case (it.reg_offset)
          OfsTpr: tmr_tpr = it.write_data[7:0];
          OfsLvt: begin
            tmr_vector   = it.write_data[VecWidth-1:0];
            tmr_masked   = it.write_data[LvtMaskBit];
            tmr_periodic = it.write_data[LvtPeriodicBit];
          end
          OfsInit: begin
            tmr_initial  = it.write_data[CountWidth-1:0];
            tmr_current  = it.write_data[CountWidth-1:0];
            tmr_prescale = '0;
          end
          OfsDiv: tmr_divide = it.write_data[3:0] & 4'b1011;
          default: ;
        endcase
      end
      OpRead: begin
        case (it.reg_offset)
          OfsTpr:  r.read_data = DataWidth'(tmr_tpr);
          OfsLvt: begin
            r.read_data = DataWidth'(tmr_vector);
            r.read_data[LvtMaskBit]     = tmr_masked;
            r.read_data[LvtPeriodicBit] = tmr_periodic;
          end
          OfsInit: r.read_data = DataWidth'(tmr_initial);
          OfsCur:  r.read_data = DataWidth'(tmr_current);
          OfsDiv:  r.read_data = DataWidth'(tmr_divide);
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one transaction, in bursts with random gaps if sender_gaps is set; predict on acceptance
  task automatic send_item(input op_e op, input logic [OfsWidth-1:0] ofs,
                           input logic [DataWidth-1:0] wdata);
    lat_in_t     it;
    int unsigned gap;
    it.opcode     = op;
    it.reg_offset = ofs;
    it.write_data = wdata;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(timer_next_result(it));
  endtask

  // Mostly valid registers, small counts and short divisors so expiries happen
  function automatic lat_in_t random_item();
    lat_in_t     it;
    int unsigned sel;
    it.write_data = $urandom();
    it.reg_offset = OfsWidth'($urandom());
    sel = $urandom_range(0, 99);
    if (sel < 62)      it.opcode = OpTick;
    else if (sel < 80) it.opcode = OpWrite;
    else if (sel < 96) it.opcode = OpRead;
    else               it.opcode = op_e'(OpReserved);
    case ($urandom_range(0, 9))
      0, 1: it.reg_offset = OfsTpr;
      2, 3: it.reg_offset = OfsLvt;
      4, 5: it.reg_offset = OfsInit;
      6:    it.reg_offset = OfsCur;
      7, 8: it.reg_offset = OfsDiv;
      default: ;
    endcase
    if (it.opcode == OpWrite && $urandom_range(0, 4) != 0) begin
      case (it.reg_offset)
        OfsInit: it.write_data = $urandom_range(1, 24);
        OfsLvt:  it.write_data[LvtMaskBit] = ($urandom_range(0, 3) == 0);
        OfsDiv: begin
          case ($urandom_range(0, 2))
            0:       {it.write_data[3], it.write_data[1:0]} = DivBy1;
            1:       {it.write_data[3], it.write_data[1:0]} = DivBy2;
            default: {it.write_data[3], it.write_data[1:0]} = DivBy4;
          endcase
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic test_reset_values();
    send_item(OpRead, OfsTpr, '0);
    send_item(OpRead, OfsLvt, '0);
    send_item(OpRead, OfsInit, '0);
    send_item(OpRead, OfsCur, '0);
    send_item(OpRead, OfsDiv, '0);
  endtask

  // All-ones writes, read-only and unknown offsets, reserved opcode
  task automatic test_register_rw();
    send_item(OpWrite, OfsTpr, '1);
    send_item(OpRead, OfsTpr, '0);
    send_item(OpWrite, OfsLvt, '1);
    send_item(OpRead, OfsLvt, '1);
    send_item(OpWrite, OfsDiv, '1);
    send_item(OpRead, OfsDiv, '0);
    send_item(OpWrite, OfsCur, 32'h1234_5678);
    send_item(OpRead, OfsCur, '0);
    send_item(OpWrite, OfsUnused, '1);
    send_item(OpRead, OfsUnused, '1);
    send_item(op_e'(OpReserved), OfsTpr, '1);
  endtask

  // Divide by 1 is set; LVT is masked, periodic, vector 0xFF
  task automatic test_timer_expiry();
    // masked periodic expiry reloads silently
    send_item(OpWrite, OfsInit, 32'd2);
    send_item(OpTick, '0, '0);
    send_item(OpTick, '0, '0);
    send_item(OpRead, OfsCur, '0);
    // unmasked one-shot expiry pulses once, then stays at zero
    send_item(OpWrite, OfsLvt, 32'h0000_005A);
    send_item(OpWrite, OfsInit, 32'd1);
    send_item(OpTick, '0, '0);
    send_item(OpTick, '0, '0);
    // largest count, then stop by writing zero
    send_item(OpWrite, OfsInit, '1);
    send_item(OpTick, '0, '0);
    send_item(OpRead, OfsCur, '0);
    send_item(OpWrite, OfsInit, '0);
    send_item(OpTick, '0, '0);
    // periodic with zero initial count stays stopped
    send_item(OpWrite, OfsLvt, 32'h0002_0000);
    send_item(OpTick, '0, '0);
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit gaps,
                                     input bit stalls);
    lat_in_t it;
    sender_gaps = gaps;
    rx_stalls   = stalls;
    repeat (count) begin
      it = random_item();
      send_item(it.opcode, it.reg_offset, it.write_data);
    end
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_input_stall();
    lat_in_t it;
    sender_gaps = 1'b0;
    hold_req    = 1'b1;
    repeat (40) begin
      it = random_item();
      send_item(it.opcode, it.reg_offset, it.write_data);
    end
  endtask

  // Receiver ready: fixed rotating stall pattern, a long hold on request, or always ready
  initial begin : rx_ctrl
    logic [12:0] pat;
    pat = 13'b1_0110_1110_1011;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_stalls) begin
        out_if.ready <= pat[0];
        pat = {pat[0], pat[12:1]};
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    lat_out_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.data.read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, got %h", exp_r.read_data, out_if.data.read_data);
          fail_count++;
        end
        if (out_if.data.interrupt_pulse !== exp_r.interrupt_pulse) begin
          $error("interrupt_pulse: expected %b, got %b", exp_r.interrupt_pulse,
                 out_if.data.interrupt_pulse);
          fail_count++;
        end
        if (out_if.data.interrupt_vector !== exp_r.interrupt_vector) begin
          $error("interrupt_vector: expected %h, got %h", exp_r.interrupt_vector,
                 out_if.data.interrupt_vector);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < WatchLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
      else idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    fail_count  = 0;
    burst_left  = 0;
    sender_gaps = 1'b1;
    rx_stalls   = 1'b1;
    hold_req    = 1'b0;
    timer_clear();
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_n       <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_register_rw();
    test_timer_expiry();
    test_random_traffic(330, 1'b1, 1'b1);
    test_input_stall();
    test_random_traffic(300, 1'b0, 1'b0);
    test_random_traffic(250, 1'b1, 1'b1);

    // drain
    in_if.valid <= 1'b0;
    rx_stalls = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lat_pkg.sv
rtl/lat_if.sv
rtl/lat_in_stage.sv
rtl/lat_timer_regs.sv
rtl/lat_out_stage.sv
rtl/local_apic_timer_core.sv
rtl/lat_checker.sv
bench/tb_local_apic_timer_core.sv
